[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Both forms are checked at the rising edge of the given clock and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/lpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [7:0] LF_CODE = 8'h0A;
	localparam logic [7:0] CR_CODE = 8'h0D;

	localparam logic [2:0] HEADER_BYTES = 3'd4;

	localparam logic [1:0] REG_MODE         = 2'd0;
	localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd1;
	localparam logic [1:0] REG_MAX_LINE_LEN = 2'd2;

	localparam logic        MODE_PACKET = 1'b0;

	localparam logic [31:0] MAX_PAYLOAD_RESET  = 32'd65536;
	localparam logic [15:0] MAX_LINE_LEN_RESET = 16'd4096;

	// Result queue depth; one item pushes at most two results.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage
`default_nettype wire

[rtl/lpd_result_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lpd_result_queue
	import lpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire push_t      push,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte
);

	result_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;
	logic [QPTR_W-1:0]   wr_ptr_next;

	assign out_valid   = (count_q != '0);
	assign pop         = out_valid && !out_stall;
	assign room        = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign kind        = entry_q[rd_ptr_q].kind;
	assign out_byte    = entry_q[rd_ptr_q].out_byte;
	assign wr_ptr_next = wr_ptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, count_q > QCNT_W'(QUEUE_DEPTH), "result queue overflow")
	`ASSERT_NEVER(a_push_needs_room, clk, arst_n, (push.count != 2'd0) && !room, "push without room")
	`ASSERT_ALWAYS(a_stalled_beat_holds, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte), "stalled result beat changed")

endmodule
`default_nettype wire

[rtl/length_prefix_or_line_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Splits a received byte stream into records, one byte per beat. In packet mode (mode 0) a
// 4-byte little-endian length header is followed by that many payload bytes, each given as a
// kind 0 result, and then a kind 1 record end; a length of zero or above max_payload gives one
// kind 2 error and closes the stream until reset. In line mode (mode 1) bytes pass through
// until a line feed, which gives a record end; one carriage return directly before the line
// feed is dropped, and a line that grows beyond max_line_len gives a kind 2 error and closes
// the stream. A byte is taken every cycle: it is registered, worked out against the stream
// state, and its zero to two results go into a four-entry result queue that drains one
// result per cycle while out_stall is low; input stalls only while that queue holds more
// than two results, and a result shows on the output from that queue. Configuration is written
// through the cfg port, which is always ready, and should be changed only while the block is idle.
module length_prefix_or_line_deframer
	import lpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       out_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic        mode_q;
	logic [31:0] max_payload_q;
	logic [15:0] max_line_len_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic        closed_q;
	logic [2:0]  hdr_cnt_q;
	logic [31:0] len_acc_q;
	logic [31:0] pay_left_q;
	logic        held_cr_q;
	logic [15:0] line_cnt_q;

	logic        closed_d;
	logic [2:0]  hdr_cnt_d;
	logic [31:0] len_acc_d;
	logic [31:0] pay_left_d;
	logic        held_cr_d;
	logic [15:0] line_cnt_d;

	logic [31:0] new_len;
	logic [31:0] pay_dec;
	logic [16:0] line_inc;
	logic        advance;
	logic        room;
	push_t       push;

	assign cfg_ready = 1'b1;
	assign advance   = room;
	assign rx_stall  = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_PACKET;
			max_payload_q  <= MAX_PAYLOAD_RESET;
			max_line_len_q <= MAX_LINE_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:         mode_q         <= cfg_data[0];
				REG_MAX_PAYLOAD:  max_payload_q  <= cfg_data;
				REG_MAX_LINE_LEN: max_line_len_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		closed_d   = closed_q;
		hdr_cnt_d  = hdr_cnt_q;
		len_acc_d  = len_acc_q;
		pay_left_d = pay_left_q;
		held_cr_d  = held_cr_q;
		line_cnt_d = line_cnt_q;
		push       = '0;

		new_len = len_acc_q;
		case (hdr_cnt_q[1:0])
			2'd0:    new_len[7:0]   = len_acc_q[7:0]   | byte_s1;
			2'd1:    new_len[15:8]  = len_acc_q[15:8]  | byte_s1;
			2'd2:    new_len[23:16] = len_acc_q[23:16] | byte_s1;
			default: new_len[31:24] = len_acc_q[31:24] | byte_s1;
		endcase
		pay_dec  = (pay_left_q != '0) ? pay_left_q - 32'd1 : pay_left_q;
		line_inc = {1'b0, line_cnt_q} + 17'd1;

		if (closed_q) begin
			// A closed stream swallows every byte.
		end else if (mode_q == MODE_PACKET) begin
			if (!hdr_cnt_q[2]) begin
				len_acc_d = new_len;
				hdr_cnt_d = hdr_cnt_q + 3'd1;
				if (hdr_cnt_q == HEADER_BYTES - 3'd1) begin
					if (new_len == '0 || new_len > max_payload_q) begin
						closed_d   = 1'b1;
						push.count = 2'd1;
						push.first = '{kind: KIND_ERROR, out_byte: 8'd0};
					end else begin
						pay_left_d = new_len;
					end
				end
			end else begin
				push.count = 2'd1;
				push.first = '{kind: KIND_BYTE, out_byte: byte_s1};
				pay_left_d = pay_dec;
				if (pay_dec == '0) begin
					push.count  = 2'd2;
					push.second = '{kind: KIND_END, out_byte: 8'd0};
					hdr_cnt_d   = 3'd0;
					len_acc_d   = '0;
				end
			end
		end else begin
			if (byte_s1 == LF_CODE) begin
				held_cr_d  = 1'b0;
				line_cnt_d = '0;
				push.count = 2'd1;
				push.first = '{kind: KIND_END, out_byte: 8'd0};
			end else if (line_inc > {1'b0, max_line_len_q}) begin
				closed_d   = 1'b1;
				held_cr_d  = 1'b0;
				push.count = 2'd1;
				push.first = '{kind: KIND_ERROR, out_byte: 8'd0};
			end else begin
				line_cnt_d = line_inc[15:0];
				held_cr_d  = (byte_s1 == CR_CODE);
				// A held carriage return goes out first, ahead of whatever follows it.
				if (held_cr_q) begin
					push.first = '{kind: KIND_BYTE, out_byte: CR_CODE};
					if (byte_s1 == CR_CODE) begin
						push.count = 2'd1;
					end else begin
						push.count  = 2'd2;
						push.second = '{kind: KIND_BYTE, out_byte: byte_s1};
					end
				end else if (byte_s1 != CR_CODE) begin
					push.count = 2'd1;
					push.first = '{kind: KIND_BYTE, out_byte: byte_s1};
				end
			end
		end

		if (!(valid_s1 && advance)) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q   <= 1'b0;
			hdr_cnt_q  <= '0;
			len_acc_q  <= '0;
			pay_left_q <= '0;
			held_cr_q  <= 1'b0;
			line_cnt_q <= '0;
		end else if (valid_s1 && advance) begin
			closed_q   <= closed_d;
			hdr_cnt_q  <= hdr_cnt_d;
			len_acc_q  <= len_acc_d;
			pay_left_q <= pay_left_d;
			held_cr_q  <= held_cr_d;
			line_cnt_q <= line_cnt_d;
		end
	end

	lpd_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte)
	);

	`ASSERT_ALWAYS(a_closed_sticky, clk, arst_n, closed_q |=> closed_q, "closed stream reopened")
	`ASSERT_NEVER(a_closed_silent, clk, arst_n, closed_q && (push.count != 2'd0), "result from a closed stream")
	`ASSERT_NEVER(a_held_cr_counted, clk, arst_n, held_cr_q && (line_cnt_q == '0), "held carriage return not counted")
	`ASSERT_NEVER(a_header_range, clk, arst_n, hdr_cnt_q > HEADER_BYTES, "header count out of range")

endmodule
`default_nettype wire

[test/record_checker.sv]
`timescale 1ns / 1ps
module record_checker
	import lpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	input  logic              rx_stall,
	input  logic [7:0]        rx_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        kind,
	input  logic [7:0]        out_byte,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output int unsigned       pending,
	output int unsigned       fails
);

	// Register copies, written as the cfg channel is seen.
	logic        mode_q;
	logic [31:0] max_payload_q;
	logic [15:0] max_line_q;

	// Stream state of the deframer.
	logic        closed;
	logic [2:0]  hdr_count;
	logic [31:0] len_acc;
	logic [31:0] payload_left;
	logic        held_cr;
	logic [15:0] line_len;

	result_t     due_results[$];
	result_t     want;

	initial begin
		pending = 0;
		fails = 0;
	end

	function automatic void queue_result(input logic [1:0] k, input logic [7:0] b);
		result_t r;
		r.kind = k;
		r.out_byte = b;
		due_results.push_back(r);
	endfunction

	function automatic void flag_field(input string field, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		fails++;
		$error("%s mismatch: expected 0x%02h, got 0x%02h", field, exp_v, act_v);
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		if (!closed) begin
			if (mode_q == MODE_PACKET) begin
				if (hdr_count < HEADER_BYTES) begin
					len_acc = len_acc | ({24'd0, b} << (8 * hdr_count));
					hdr_count = hdr_count + 3'd1;
					if (hdr_count == HEADER_BYTES) begin
						if (len_acc == 32'd0 || len_acc > max_payload_q) begin
							closed = 1'b1;
							queue_result(KIND_ERROR, 8'd0);
						end else begin
							payload_left = len_acc;
						end
					end
				end else begin
					queue_result(KIND_BYTE, b);
					if (payload_left != 32'd0)
						payload_left = payload_left - 32'd1;
					if (payload_left == 32'd0) begin
						queue_result(KIND_END, 8'd0);
						hdr_count = 3'd0;
						len_acc = 32'd0;
					end
				end
			end else if (b == LF_CODE) begin
				held_cr = 1'b0;
				line_len = 16'd0;
				queue_result(KIND_END, 8'd0);
			end else if ({1'b0, line_len} + 17'd1 > {1'b0, max_line_q}) begin
				// Overlong line: any held carriage return is lost with the error.
				closed = 1'b1;
				held_cr = 1'b0;
				queue_result(KIND_ERROR, 8'd0);
			end else begin
				line_len = line_len + 16'd1;
				if (held_cr)
					queue_result(KIND_BYTE, CR_CODE);
				if (b == CR_CODE) begin
					held_cr = 1'b1;
				end else begin
					held_cr = 1'b0;
					queue_result(KIND_BYTE, b);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_PACKET;
			max_payload_q = MAX_PAYLOAD_RESET;
			max_line_q = MAX_LINE_LEN_RESET;
			closed = 1'b0;
			hdr_count = 3'd0;
			len_acc = 32'd0;
			payload_left = 32'd0;
			held_cr = 1'b0;
			line_len = 16'd0;
			due_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					fails++;
					$error("unexpected result: kind %0d, out_byte 0x%02h", kind, out_byte);
				end else begin
					want = due_results.pop_front();
					if (kind !== want.kind)
						flag_field("kind", {6'd0, want.kind}, {6'd0, kind});
					if (out_byte !== want.out_byte)
						flag_field("out_byte", want.out_byte, out_byte);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE: mode_q = cfg_data[0];
					REG_MAX_PAYLOAD: max_payload_q = cfg_data;
					REG_MAX_LINE_LEN: max_line_q = cfg_data[15:0];
					default: ;
				endcase
			end
			if (rx_valid && !rx_stall)
				deframe_byte(rx_byte);
		end
		pending = due_results.size();
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import lpd_pkg::*;

	localparam logic       MODE_LINE  = 1'b1;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;

	int unsigned pending;
	int unsigned fails;

	// When set, neither side inserts gaps or stalls.
	bit          quiet = 1'b0;
	int          stall_left = 0;
	int          stall_draw;
	int unsigned sent = 0;

	logic        cur_mode = MODE_PACKET;
	logic [31:0] cur_max_payload = MAX_PAYLOAD_RESET;
	logic [15:0] cur_max_line = MAX_LINE_LEN_RESET;

	length_prefix_or_line_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	record_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.fails(fails)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// After each result beat the receiver holds off for a random number of cycles.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			stall_draw = quiet ? 0 : $urandom_range(0, 4);
			out_stall <= (stall_draw != 0);
			stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		sent++;
	endtask

	// Stop sending and wait until every predicted result has been taken.
	task automatic settle();
		rx_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_regs(input logic m, input logic [31:0] mp, input logic [15:0] ml);
		write_reg(REG_MODE, {31'd0, m});
		write_reg(REG_MAX_PAYLOAD, mp);
		write_reg(REG_MAX_LINE_LEN, {16'd0, ml});
		cfg_valid <= 1'b0;
		cur_mode = m;
		cur_max_payload = mp;
		cur_max_line = ml;
	endtask

	task automatic send_header(input logic [31:0] len);
		for (int i = 0; i < 4; i++)
			send_byte(len[8 * i +: 8]);
	endtask

	function automatic logic [7:0] line_char();
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0) begin
			c = CR_CODE;
		end else begin
			c = 8'($urandom_range(0, 255));
			if (c == LF_CODE)
				c = 8'h20;
		end
		return c;
	endfunction

	task automatic send_packet(input int len);
		logic [7:0] c;
		send_header(32'(len));
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0: c = LF_CODE;
				1: c = CR_CODE;
				default: c = 8'($urandom_range(0, 255));
			endcase
			send_byte(c);
		end
	endtask

	// A line of len counted bytes; sometimes the last of them is a carriage return.
	task automatic send_line(input int len);
		bit cr_tail;
		cr_tail = (len > 0) && ($urandom_range(0, 2) == 0);
		for (int i = 0; i < len; i++)
			send_byte((cr_tail && i == len - 1) ? CR_CODE : line_char());
		send_byte(LF_CODE);
	endtask

	initial begin
		int cap;
		int lim;
		int records;
		int variant;
		int waited;
		logic        m;
		logic [31:0] mp;
		logic [15:0] ml;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Packet mode at reset values: shortest length, then raw LF and CR as payload.
		send_header(32'd1); send_byte(8'hFF);
		send_header(32'd3); send_byte(8'h00); send_byte(LF_CODE); send_byte(CR_CODE);
		// Leave a packet half done, run some lines, then finish it.
		send_header(32'd2); send_byte(8'h55);
		settle();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		write_reg(REG_MODE, {31'd0, MODE_LINE});
		cfg_valid <= 1'b0;
		cur_mode = MODE_LINE;
		send_byte(CR_CODE); send_byte(LF_CODE);
		send_byte(LF_CODE);
		send_byte(CR_CODE); send_byte(CR_CODE); send_byte(8'h41); send_byte(LF_CODE);
		settle();
		write_reg(REG_MODE, {31'd0, MODE_PACKET});
		cfg_valid <= 1'b0;
		cur_mode = MODE_PACKET;
		send_byte(8'hAA);

		while (sent < 680) begin
			settle();
			m = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 4))
				0: mp = 32'd1;
				1: mp = $urandom_range(2, 30);
				2: mp = MAX_PAYLOAD_RESET;
				3: mp = 32'hFFFF_FFFF;
				default: mp = $urandom | 32'd1;
			endcase
			case ($urandom_range(0, 4))
				0: ml = 16'd0;
				1: ml = 16'd1;
				2: ml = 16'($urandom_range(2, 30));
				3: ml = 16'hFFFF;
				default: ml = MAX_LINE_LEN_RESET;
			endcase
			set_regs(m, mp, ml);
			quiet = ($urandom_range(0, 3) == 0);
			records = $urandom_range(4, 12);
			for (int r = 0; r < records; r++) begin
				cap = ($urandom_range(0, 19) == 0) ? 200 : 12;
				if (cur_mode == MODE_PACKET) begin
					lim = (cur_max_payload < cap) ? int'(cur_max_payload) : cap;
					send_packet($urandom_range(1, lim));
				end else begin
					lim = (cur_max_line < cap) ? int'(cur_max_line) : cap;
					send_line($urandom_range(0, lim));
				end
				if ($urandom_range(0, 9) == 0)
					settle();
			end
		end

		// The stream closes for good on a framing error, so it comes last.
		settle();
		quiet = 1'b0;
		variant = $urandom_range(0, 2);
		case (variant)
			0: begin
				set_regs(MODE_PACKET, cur_max_payload | 32'd1, cur_max_line);
				send_header(32'd0);
			end
			1: begin
				case ($urandom_range(0, 2))
					0: mp = 32'd0;
					1: mp = $urandom_range(1, 300);
					default: mp = $urandom & 32'h7FFF_FFFF;
				endcase
				set_regs(MODE_PACKET, mp, cur_max_line);
				send_header(mp + 32'd1 + $urandom_range(0, 2));
			end
			default: begin
				ml = 16'($urandom_range(0, 6));
				set_regs(MODE_LINE, cur_max_payload, ml);
				for (int i = 0; i < ml; i++)
					send_byte((i == ml - 1 && $urandom_range(0, 1) == 0) ? CR_CODE : line_char());
				send_byte(line_char());
			end
		endcase
		// Everything after the error must be dropped.
		repeat (12) send_byte(8'($urandom_range(0, 255)));

		rx_valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < 5000);
		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
